/* src/gcsp_pkg.sv */
// ----------------------------------------------------------------------------
// gcsp_pkg
// Shared types and constants of the grid coverage step planner: map size,
// cell codes, item actions, move codes, register indexes and sequencer state.
// ----------------------------------------------------------------------------
package gcsp_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int MAP_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int MAP_AW      = $clog2(MAP_DEPTH);
  localparam int EFF_WW      = $clog2(MAX_WIDTH + 1);
  localparam int EFF_HW      = $clog2(MAX_HEIGHT + 1);

  localparam int CFG_W       = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int POS_W       = 6;
  localparam int DIST_W      = 14;
  localparam int DIST_START  = 10000;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    CELL_BLOCKED = 2'd0,
    CELL_FREE    = 2'd1,
    CELL_CLEANED = 2'd2
  } cell_t;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_POS   = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    MOVE_JUMP  = 3'd0,
    MOVE_EAST  = 3'd1,
    MOVE_WEST  = 3'd2,
    MOVE_SOUTH = 3'd3,
    MOVE_NORTH = 3'd4,
    MOVE_DONE  = 3'd5,
    MOVE_ACK   = 3'd6
  } move_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CLEAN,
    ST_RD_N,
    ST_RD_S,
    ST_RD_W,
    ST_RD_E,
    ST_DECIDE,
    ST_SCAN,
    ST_SCAN_END,
    ST_JUMP,
    ST_RESULT
  } state_t;

  // one access to the map memory
  typedef struct packed {
    logic  we;
    logic  re;
    cell_t wdata;
  } mem_ctl_t;

  typedef struct packed {
    move_t             code;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
  } result_t;

endpackage

/* src/grid_coverage_step_planner.sv */
// ----------------------------------------------------------------------------
// grid_coverage_step_planner
// Coverage planner over a grid map: cell writes, robot placement and single
// coverage steps with neighbor moves or a jump to the nearest free cell.
//
//   channel   signals                                   direction
//   item      item_valid/item_stall, action, cell_x,    in
//             cell_y, cell_free
//   result    result_valid/result_stall, move_code,     out
//             pos_x, pos_y
//   config    cfg_write, cfg_index, cfg_data            in
//
// A position set or an unused action goes straight to the result state; a cell
// write first passes the write state, a step that moves the clean, four neighbor
// read and decide states. A stuck step adds a scan of eff_width*eff_height cells,
// one map read per cycle through the single memory port, then scan end and jump;
// an empty grid adds jump only. After reset every map entry is swept to blocked
// with item_stall high; configuration writes are taken during the sweep.
// One item is in work at a time; a new item is taken while the previous
// result waits in the output register under result_stall.
// ----------------------------------------------------------------------------
module grid_coverage_step_planner (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic [1:0]                            action,
  input  logic [5:0]                            cell_x,
  input  logic [5:0]                            cell_y,
  input  logic                                  cell_free,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [2:0]                            move_code,
  output logic [5:0]                            pos_x,
  output logic [5:0]                            pos_y,
  input  logic                                  cfg_write,
  input  logic [gcsp_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [gcsp_pkg::CFG_W-1:0]            cfg_data
);
  import gcsp_pkg::*;

  localparam int DEPTH = MAP_DEPTH;
  localparam int AW    = MAP_AW;
  localparam int EW    = EFF_WW;
  localparam int EH    = EFF_HW;
  localparam int WCW   = (EW > CFG_W) ? EW : CFG_W;
  localparam int HCW   = (EH > CFG_W) ? EH : CFG_W;

  logic [CFG_W-1:0] grid_width, grid_height;
  logic [EW-1:0]    eff_w;
  logic [EH-1:0]    eff_h;
  mem_ctl_t         ctl;
  logic [AW-1:0]    addr;
  cell_t            rdata;
  logic             map_busy;
  logic             res_room, res_load;
  result_t          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= CFG_W'(64);
      grid_height <= CFG_W'(64);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp register values to the map size
  assign eff_w = (WCW'(grid_width) > WCW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(grid_width);
  assign eff_h = (HCW'(grid_height) > HCW'(MAX_HEIGHT)) ? EH'(MAX_HEIGHT)
                                                        : EH'(grid_height);

  gcsp_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .action     (action_t'(action)),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_free  (cell_free),
    .eff_w      (eff_w),
    .eff_h      (eff_h),
    .map_busy   (map_busy),
    .ctl        (ctl),
    .addr       (addr),
    .rdata      (rdata),
    .res_room   (res_room),
    .res_load   (res_load),
    .res        (res)
  );

  gcsp_map #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .addr  (addr),
    .rdata (rdata),
    .busy  (map_busy)
  );

  // output word register; refill in the cycle the held word is taken
  assign res_room = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      move_code <= res.code;
      pos_x     <= res.x;
      pos_y     <= res.y;
    end
  end

endmodule

/* src/gcsp_map.sv */
// ----------------------------------------------------------------------------
// gcsp_map
// Cell map memory: one port, read or write per cycle, registered read data.
// After reset it sweeps every entry to blocked, one per cycle, with busy high.
// ----------------------------------------------------------------------------
module gcsp_map #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  gcsp_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]     addr,
  output gcsp_pkg::cell_t   rdata,
  output logic              busy
);
  import gcsp_pkg::*;

  cell_t         mem [DEPTH];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= CELL_BLOCKED;
    end else if (ctl.we) begin
      mem[addr] <= ctl.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[addr];
    end
  end

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(ctl.we && ctl.re))
    else $error("map read and write in the same cycle");

  a_quiet_while_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> !ctl.we && !ctl.re)
    else $error("map accessed during clearing sweep");

  a_sweep_complete: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(clr_addr) == AW'(DEPTH - 1))
    else $error("clearing sweep ended early");

endmodule

/* src/gcsp_seq.sv */
// ----------------------------------------------------------------------------
// gcsp_seq
// Step sequencer: holds the robot position, reads the four neighbors from the
// map, picks a move, and otherwise scans the map for the nearest free cell.
// ----------------------------------------------------------------------------
module gcsp_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  gcsp_pkg::action_t             action,
  input  logic [5:0]                    cell_x,
  input  logic [5:0]                    cell_y,
  input  logic                          cell_free,
  input  logic [gcsp_pkg::EFF_WW-1:0]   eff_w,
  input  logic [gcsp_pkg::EFF_HW-1:0]   eff_h,
  input  logic                          map_busy,
  output gcsp_pkg::mem_ctl_t            ctl,
  output logic [gcsp_pkg::MAP_AW-1:0]   addr,
  input  gcsp_pkg::cell_t               rdata,
  input  logic                          res_room,
  output logic                          res_load,
  output gcsp_pkg::result_t             res
);
  import gcsp_pkg::*;

  localparam int EW  = EFF_WW;
  localparam int EH  = EFF_HW;
  localparam int AW  = MAP_AW;
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int OW0 = (EW > EH) ? EW : EH;
  localparam int OW  = (OW0 > 7) ? OW0 : 7;
  localparam int CW0 = (XW > YW) ? XW : YW;
  localparam int CW  = (CW0 > 7) ? CW0 : 7;

  function automatic logic on_grid(input logic [6:0] x, input logic [6:0] y,
                                   input logic [EW-1:0] w, input logic [EH-1:0] h);
    return (OW'(x) < OW'(w)) && (OW'(y) < OW'(h));
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x,
                                            input logic [CW-1:0] y);
    return AW'(AW'(y) * AW'(MAX_WIDTH) + AW'(x));
  endfunction

  state_t              state, state_next;
  logic [POS_W-1:0]    robot_x, robot_y;
  logic [POS_W-1:0]    it_x, it_y;
  logic                it_free;
  move_t               code;
  logic                n_free, s_free, w_free;
  logic [XW-1:0]       sx;
  logic [YW-1:0]       sy;
  logic                p_valid;
  logic [DIST_W-1:0]   p_d;
  logic [XW-1:0]       p_x;
  logic [YW-1:0]       p_y;
  logic [DIST_W-1:0]   best;
  logic [XW-1:0]       bx;
  logic [YW-1:0]       by;
  logic                found;

  logic [6:0]          x7, y7;
  logic                grid_c, grid_n, grid_s, grid_w, grid_e;
  logic                fn, fs, fw, fe, any_move, empty;
  logic                last_y, last_xy, take, accept;
  logic [DIST_W-1:0]   sxd, syd, rxd, ryd, dx, dy, d;

  assign x7 = {1'b0, robot_x};
  assign y7 = {1'b0, robot_y};

  // neighbor on-grid tests; guard the wrap below zero
  assign grid_c = on_grid(x7, y7, eff_w, eff_h);
  assign grid_n = (robot_y != '0) && on_grid(x7, y7 - 7'd1, eff_w, eff_h);
  assign grid_s = on_grid(x7, y7 + 7'd1, eff_w, eff_h);
  assign grid_w = (robot_x != '0) && on_grid(x7 - 7'd1, y7, eff_w, eff_h);
  assign grid_e = on_grid(x7 + 7'd1, y7, eff_w, eff_h);

  assign fn = grid_n && n_free;
  assign fs = grid_s && s_free;
  assign fw = grid_w && w_free;
  assign fe = grid_e && (rdata == CELL_FREE);
  assign any_move = fn || fs || fw || fe;
  assign empty = (eff_w == '0) || (eff_h == '0);

  assign last_y  = (EH'(sy) == eff_h - 1'b1);
  assign last_xy = last_y && (EW'(sx) == eff_w - 1'b1);

  // distance of the scan cell, computed while its read is in flight
  assign sxd = DIST_W'(sx);
  assign syd = DIST_W'(sy);
  assign rxd = DIST_W'(robot_x);
  assign ryd = DIST_W'(robot_y);
  assign dx  = (sxd >= rxd) ? sxd - rxd : rxd - sxd;
  assign dy  = (syd >= ryd) ? syd - ryd : ryd - syd;
  assign d   = dx + dy;

  assign take   = p_valid && (rdata == CELL_FREE) && (p_d < best);
  assign accept = item_valid && !item_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid && !map_busy) begin
          case (action)
            ACT_WRITE: state_next = ST_WRITE;
            ACT_STEP:  state_next = ST_CLEAN;
            default:   state_next = ST_RESULT;
          endcase
        end
      end
      ST_WRITE:    state_next = ST_RESULT;
      ST_CLEAN:    state_next = ST_RD_N;
      ST_RD_N:     state_next = ST_RD_S;
      ST_RD_S:     state_next = ST_RD_W;
      ST_RD_W:     state_next = ST_RD_E;
      ST_RD_E:     state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (any_move) begin
          state_next = ST_RESULT;
        end else if (empty) begin
          state_next = ST_JUMP;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_xy) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_next = ST_JUMP;
      ST_JUMP:     state_next = ST_RESULT;
      ST_RESULT: begin
        if (res_room) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = (state != ST_IDLE) || map_busy;
    ctl        = '{we: 1'b0, re: 1'b0, wdata: CELL_BLOCKED};
    addr       = '0;
    res_load   = 1'b0;
    case (state)
      ST_WRITE: begin
        ctl.we    = on_grid({1'b0, it_x}, {1'b0, it_y}, eff_w, eff_h);
        ctl.wdata = it_free ? CELL_FREE : CELL_BLOCKED;
        addr      = addr_of(CW'(it_x), CW'(it_y));
      end
      ST_CLEAN: begin
        ctl.we    = grid_c;
        ctl.wdata = CELL_CLEANED;
        addr      = addr_of(CW'(x7), CW'(y7));
      end
      ST_RD_N: begin
        ctl.re = 1'b1;
        addr   = addr_of(CW'(x7), CW'(y7 - 7'd1));
      end
      ST_RD_S: begin
        ctl.re = 1'b1;
        addr   = addr_of(CW'(x7), CW'(y7 + 7'd1));
      end
      ST_RD_W: begin
        ctl.re = 1'b1;
        addr   = addr_of(CW'(x7 - 7'd1), CW'(y7));
      end
      ST_RD_E: begin
        ctl.re = 1'b1;
        addr   = addr_of(CW'(x7 + 7'd1), CW'(y7));
      end
      ST_SCAN: begin
        ctl.re = 1'b1;
        addr   = addr_of(CW'(sx), CW'(sy));
      end
      ST_RESULT: res_load = res_room;
      default: ;
    endcase
  end

  assign res = '{code: code, x: robot_x, y: robot_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      robot_x <= '0;
      robot_y <= '0;
      p_valid <= 1'b0;
    end else begin
      state   <= state_next;
      p_valid <= (state == ST_SCAN);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            it_x    <= cell_x;
            it_y    <= cell_y;
            it_free <= cell_free;
            code    <= MOVE_ACK;
            if (action == ACT_POS) begin
              robot_x <= cell_x;
              robot_y <= cell_y;
            end
          end
        end
        ST_RD_S: n_free <= (rdata == CELL_FREE);
        ST_RD_W: s_free <= (rdata == CELL_FREE);
        ST_RD_E: w_free <= (rdata == CELL_FREE);
        ST_DECIDE: begin
          sx    <= '0;
          sy    <= '0;
          best  <= DIST_W'(DIST_START);
          found <= 1'b0;
          if (fs && fw) begin
            robot_x <= robot_x - 1'b1;
            code    <= MOVE_WEST;
          end else if (fn && fw) begin
            robot_x <= robot_x - 1'b1;
            code    <= MOVE_WEST;
          end else if (fn && fs) begin
            robot_y <= robot_y + 1'b1;
            code    <= MOVE_SOUTH;
          end else if (fn) begin
            robot_y <= robot_y - 1'b1;
            code    <= MOVE_NORTH;
          end else if (fs) begin
            robot_y <= robot_y + 1'b1;
            code    <= MOVE_SOUTH;
          end else if (fw) begin
            robot_x <= robot_x - 1'b1;
            code    <= MOVE_WEST;
          end else if (fe) begin
            robot_x <= robot_x + 1'b1;
            code    <= MOVE_EAST;
          end
        end
        ST_SCAN: begin
          p_d <= d;
          p_x <= sx;
          p_y <= sy;
          // y inner, x outer
          if (last_y) begin
            sy <= '0;
            sx <= sx + 1'b1;
          end else begin
            sy <= sy + 1'b1;
          end
        end
        ST_JUMP: begin
          if (found) begin
            robot_x <= POS_W'(bx);
            robot_y <= POS_W'(by);
            code    <= MOVE_JUMP;
          end else begin
            code    <= MOVE_DONE;
          end
        end
        default: ;
      endcase
      // strict less-than keeps the first cell on ties
      if (take) begin
        best  <= p_d;
        bx    <= p_x;
        by    <= p_y;
        found <= 1'b1;
      end
    end
  end

  a_found_has_distance: assert property (@(posedge clk) disable iff (rst)
    (state == ST_JUMP) && found |-> best < DIST_W'(DIST_START))
    else $error("nearest cell found without a distance");

  a_compare_follows_scan: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> $past(state) == ST_SCAN)
    else $error("scan compare without a scan read");

endmodule
